// ===== hw/rtl/dmsc_pkg.sv =====
`default_nettype none
// ============================================================================
// dmsc_pkg
// Shared types and constants of the Bayer demosaic block.
// ============================================================================
package dmsc_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIX_W         = 16;
    localparam int FW_W          = 11;
    localparam int FH_W          = 16;
    localparam int CFG_W         = 16;
    localparam int ROW_W         = FH_W + 1;

    localparam int DIV_NUM_W     = 35;
    localparam int DIV_DEN_W     = 20;
    localparam int WGT_W         = 17;
    localparam int DSUM_W        = 19;
    localparam int PROD_W        = WGT_W + PIX_W;

    localparam logic [DIV_NUM_W-1:0] WGT_NUMER = 35'h0_FFFF_0000;

    typedef enum logic [1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_PATTERN,
        CFG_EDGE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PAT_RGGB,
        PAT_BGGR,
        PAT_GRBG,
        PAT_GBRG
    } t_pattern;

    typedef enum logic [1:0] {
        SITE_RED,
        SITE_BLUE,
        SITE_GRN_RROW,
        SITE_GRN_BROW
    } t_site;

    typedef enum logic {
        F_IDLE,
        F_READ
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_START,
        B_DIV_W,
        B_MUL,
        B_ACC,
        B_FSTART,
        B_DIV_F,
        B_DONE
    } t_bstate;

    typedef struct packed {
        logic [PIX_W-1:0] mosaic_pixel;
        logic             drain;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_end;
    } t_out;

    typedef struct packed {
        t_site                 site;
        logic [PIX_W-1:0]      center;
        logic [3:0][PIX_W-1:0] orth;
        logic [3:0][PIX_W-1:0] diag;
        logic                  frame_end;
    } t_job;

endpackage
`default_nettype wire

// ===== hw/rtl/dmsc_ram.sv =====
`default_nettype none
// ============================================================================
// dmsc_ram
// Simple dual-port RAM with one write port and a registered read port.
// ============================================================================
module dmsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hw/rtl/dmsc_front.sv =====
`default_nettype none
// ============================================================================
// dmsc_front
// Accepts mosaic samples, keeps two line stores and the 3x3 window with
// border replication, and classifies each output site into a job.
// ============================================================================
module dmsc_front
    import dmsc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW       = $clog2(MAX_WIDTH),
    localparam int WW       = $clog2(MAX_WIDTH + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_clear,
    input  wire logic [WW-1:0]   i_width,
    input  wire logic [FH_W-1:0] i_height,
    input  wire t_pattern        i_pattern,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire t_in             i_item,
    output logic                 o_push,
    output t_job                 o_job,
    input  wire logic            i_full
);

    t_fstate r_state, n_state;

    logic [CW-1:0]              r_cx;
    logic [CW-1:0]              r_sx;
    logic [ROW_W-1:0]           r_cy;
    logic [FH_W-1:0]            r_sy;
    logic [PIX_W-1:0]           r_pix;
    logic [2:0][PIX_W-1:0]      r_t1;
    logic [2:0][PIX_W-1:0]      r_t2;

    logic [PIX_W-1:0]           a_q;
    logic [PIX_W-1:0]           b_q;
    logic [2:0][PIX_W-1:0]      nt;
    logic [2:0][PIX_W-1:0]      col_l;
    logic [2:0][PIX_W-1:0]      col_m;
    logic [2:0][PIX_W-1:0]      col_r;
    logic [8:0][PIX_W-1:0]      win;

    logic            accept;
    logic            pix_phase;
    logic            skip;
    logic            start_rd;
    logic            produce;
    logic            last;
    logic            leave;
    logic            col_last;
    logic            sx_last;
    logic            sy_first;
    logic            sy_last;
    logic [WW-1:0]   wm1;
    logic [FH_W-1:0] hm1;
    logic [ROW_W-1:0] hp1;
    logic            rx;
    logic            ry;

    function automatic logic [2:0][PIX_W-1:0] vclamp(
        input logic [2:0][PIX_W-1:0] col,
        input logic                  top0,
        input logic                  botl
    );
        logic [2:0][PIX_W-1:0] res;
        res    = col;
        res[0] = top0 ? col[1] : col[0];
        res[2] = botl ? col[1] : col[2];
        return res;
    endfunction

    assign wm1       = i_width - WW'(1);
    assign hm1       = i_height - FH_W'(1);
    assign hp1       = ROW_W'(i_height) + ROW_W'(1);
    assign pix_phase = r_cy < ROW_W'(i_height);
    assign produce   = (r_cy >= ROW_W'(2)) || ((r_cy == ROW_W'(1)) && (r_cx != '0));
    assign last      = (r_cy == hp1) && (r_cx == '0);
    assign col_last  = WW'(r_cx) == wm1;
    assign sx_last   = WW'(r_sx) == wm1;
    assign sy_first  = r_sy == '0;
    assign sy_last   = r_sy == hm1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (start_rd) begin
                    n_state = F_READ;
                end
            end
            F_READ: begin
                if (leave) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = r_state == F_IDLE;
        accept   = i_valid && o_ready;
        skip     = accept && i_item.drain && pix_phase;
        start_rd = accept && !skip;
        leave    = (r_state == F_READ) && (!produce || !i_full);
        o_push   = leave && produce;
    end

    dmsc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .i_clk   (i_clk),
        .i_we    (leave),
        .i_waddr (r_cx),
        .i_wdata (r_pix),
        .i_re    (start_rd),
        .i_raddr (r_cx),
        .o_rdata (a_q)
    );

    dmsc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .i_clk   (i_clk),
        .i_we    (leave),
        .i_waddr (r_cx),
        .i_wdata (a_q),
        .i_re    (start_rd),
        .i_raddr (r_cx),
        .o_rdata (b_q)
    );

    always_comb begin
        nt[0] = b_q;
        nt[1] = a_q;
        nt[2] = r_pix;
        col_m = vclamp(r_t1, sy_first, sy_last);
        col_l = vclamp((r_sx == '0) ? r_t1 : r_t2, sy_first, sy_last);
        col_r = vclamp(sx_last ? r_t1 : nt, sy_first, sy_last);
        win[0] = col_l[0];
        win[1] = col_m[0];
        win[2] = col_r[0];
        win[3] = col_l[1];
        win[4] = col_m[1];
        win[5] = col_r[1];
        win[6] = col_l[2];
        win[7] = col_m[2];
        win[8] = col_r[2];
    end

    always_comb begin
        rx = (i_pattern == PAT_BGGR) || (i_pattern == PAT_GRBG);
        ry = (i_pattern == PAT_BGGR) || (i_pattern == PAT_GBRG);
        o_job.center    = win[4];
        o_job.orth[0]   = win[3];
        o_job.orth[1]   = win[5];
        o_job.orth[2]   = win[1];
        o_job.orth[3]   = win[7];
        o_job.diag[0]   = win[0];
        o_job.diag[1]   = win[2];
        o_job.diag[2]   = win[6];
        o_job.diag[3]   = win[8];
        o_job.frame_end = last;
        if ((r_sx[0] == rx) && (r_sy[0] == ry)) begin
            o_job.site = SITE_RED;
        end else if ((r_sx[0] != rx) && (r_sy[0] != ry)) begin
            o_job.site = SITE_BLUE;
        end else if (r_sy[0] == ry) begin
            o_job.site = SITE_GRN_RROW;
        end else begin
            o_job.site = SITE_GRN_BROW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cx    <= '0;
            r_cy    <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
        end else if (i_clear) begin
            r_state <= F_IDLE;
            r_cx    <= '0;
            r_cy    <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
        end else begin
            r_state <= n_state;
            if (leave) begin
                if (last) begin
                    r_cx <= '0;
                    r_cy <= '0;
                    r_sx <= '0;
                    r_sy <= '0;
                end else begin
                    if (col_last) begin
                        r_cx <= '0;
                        r_cy <= r_cy + ROW_W'(1);
                    end else begin
                        r_cx <= r_cx + CW'(1);
                    end
                    if (produce) begin
                        if (sx_last) begin
                            r_sx <= '0;
                            r_sy <= r_sy + FH_W'(1);
                        end else begin
                            r_sx <= r_sx + CW'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_rd) begin
            r_pix <= i_item.mosaic_pixel;
        end
        if (leave) begin
            r_t2 <= r_t1;
            r_t1 <= nt;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dmsc_queue.sv =====
`default_nettype none
// ============================================================================
// dmsc_queue
// Two-entry job queue between the window front end and the interpolator.
// ============================================================================
module dmsc_queue
    import dmsc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dmsc_div.sv =====
`default_nettype none
// ============================================================================
// dmsc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module dmsc_div
    import dmsc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_NUM_W-1:0] i_numer,
    input  wire logic [DIV_DEN_W-1:0] i_denom,
    output logic                      o_done,
    output logic      [DIV_NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign trial  = {r_rem, r_quo[DIV_NUM_W-1]};
    assign fits   = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_numer;
            r_den <= i_denom;
        end else if (r_busy) begin
            r_rem <= fits ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], fits};
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dmsc_back.sv =====
`default_nettype none
// ============================================================================
// dmsc_back
// Interpolates the two missing colors of each job, by rounded mean or by
// difference-weighted mean, and holds the finished pixel in an output register.
// ============================================================================
module dmsc_back
    import dmsc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_edge,
    input  wire logic i_empty,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    t_bstate r_state, n_state;

    logic                 r_op;
    logic [1:0]           r_i;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DSUM_W-1:0]    r_den;
    logic [PROD_W-1:0]    r_prod;
    logic [1:0][PIX_W-1:0] r_res;
    logic                 r_ovalid;
    t_out                 r_out;

    logic                 green;
    logic                 last_i;
    logic [PIX_W-1:0]     p;
    logic [PIX_W-1:0]     diff;
    logic [DIV_DEN_W-1:0] dval;
    logic [DIV_NUM_W-1:0] wnum;
    logic [DIV_NUM_W-1:0] fnum;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_numer;
    logic [DIV_DEN_W-1:0] div_denom;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic                 load;
    logic [17:0]          s_cross;
    logic [17:0]          s_diag;
    logic [17:0]          s_h;
    logic [17:0]          s_v;
    logic [PIX_W-1:0]     bil0;
    logic [PIX_W-1:0]     bil1;
    t_out                 pix;

    always_comb begin
        green  = (i_job.site == SITE_GRN_RROW) || (i_job.site == SITE_GRN_BROW);
        last_i = green ? (r_i == 2'd1) : (r_i == 2'd3);
        if (!r_op) begin
            p = i_job.orth[r_i];
        end else if (green) begin
            p = i_job.orth[{1'b1, r_i[0]}];
        end else begin
            p = i_job.diag[r_i];
        end
        diff = (i_job.center > p) ? (i_job.center - p) : (p - i_job.center);
        dval = DIV_DEN_W'(65535) + DIV_DEN_W'({diff, 3'b000}) + DIV_DEN_W'({diff, 1'b0});
        wnum = WGT_NUMER + DIV_NUM_W'(dval >> 1);
        fnum = r_num + DIV_NUM_W'(r_den >> 1);
    end

    always_comb begin
        s_h     = 18'(i_job.orth[0]) + 18'(i_job.orth[1]);
        s_v     = 18'(i_job.orth[2]) + 18'(i_job.orth[3]);
        s_cross = s_h + s_v;
        s_diag  = 18'(i_job.diag[0]) + 18'(i_job.diag[1])
                + 18'(i_job.diag[2]) + 18'(i_job.diag[3]);
        bil0    = green ? PIX_W'((s_h + 18'd1) >> 1) : PIX_W'((s_cross + 18'd2) >> 2);
        bil1    = green ? PIX_W'((s_v + 18'd1) >> 1) : PIX_W'((s_diag + 18'd2) >> 2);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = i_edge ? B_START : B_DONE;
                end
            end
            B_START:  n_state = B_DIV_W;
            B_DIV_W: begin
                if (div_done) begin
                    n_state = B_MUL;
                end
            end
            B_MUL:    n_state = B_ACC;
            B_ACC:    n_state = last_i ? B_FSTART : B_START;
            B_FSTART: n_state = B_DIV_F;
            B_DIV_F: begin
                if (div_done) begin
                    n_state = r_op ? B_DONE : B_START;
                end
            end
            B_DONE: begin
                if (load) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        div_start = (r_state == B_START) || (r_state == B_FSTART);
        div_numer = (r_state == B_FSTART) ? fnum : wnum;
        div_denom = (r_state == B_FSTART) ? DIV_DEN_W'(r_den) : dval;
        load      = (r_state == B_DONE) && (!r_ovalid || i_ready);
        o_pop     = load;
        o_valid   = r_ovalid;
        o_data    = r_out;
    end

    always_comb begin
        pix.frame_end = i_job.frame_end;
        case (i_job.site)
            SITE_RED: begin
                pix.red   = i_job.center;
                pix.green = r_res[0];
                pix.blue  = r_res[1];
            end
            SITE_BLUE: begin
                pix.blue  = i_job.center;
                pix.green = r_res[0];
                pix.red   = r_res[1];
            end
            SITE_GRN_RROW: begin
                pix.green = i_job.center;
                pix.red   = r_res[0];
                pix.blue  = r_res[1];
            end
            default: begin
                pix.green = i_job.center;
                pix.blue  = r_res[0];
                pix.red   = r_res[1];
            end
        endcase
    end

    dmsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (div_numer),
        .i_denom (div_denom),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_op     <= 1'b0;
                r_i      <= 2'd0;
                r_num    <= '0;
                r_den    <= '0;
                r_res[0] <= bil0;
                r_res[1] <= bil1;
            end
            B_DIV_W: begin
                if (div_done) begin
                    r_prod <= div_quot[WGT_W-1:0] * p;
                    r_den  <= r_den + DSUM_W'(div_quot[WGT_W-1:0]);
                end
            end
            B_MUL: begin
                r_num <= r_num + DIV_NUM_W'(r_prod);
            end
            B_ACC: begin
                if (!last_i) begin
                    r_i <= r_i + 2'd1;
                end
            end
            B_DIV_F: begin
                if (div_done) begin
                    r_res[r_op] <= div_quot[PIX_W-1:0];
                    r_op        <= 1'b1;
                    r_i         <= 2'd0;
                    r_num       <= '0;
                    r_den       <= '0;
                end
            end
            B_DONE: begin
                if (load) begin
                    r_out <= pix;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bayer_demosaic_edge_aware_top.sv =====
`default_nettype none
// ============================================================================
// bayer_demosaic_edge_aware_top
// Streaming Bayer demosaic with bilinear or edge-weighted interpolation.
// ============================================================================
// Raw samples enter in raster order and one RGB pixel leaves per site, W+1
// transfers after its own sample; W+1 drain transfers after the last sample
// flush the frame. The front end takes a new sample only after the registered
// read of its two line memories for the last one, and a two-entry job queue
// lets it run ahead of the interpolator. In averaging mode a pixel passes only
// the idle and done states of the interpolator. In edge mode every neighbor
// weight and each of the two final quotients goes through one shared
// bit-serial divider; a weight passes its start, divide, multiply and
// accumulate states and a quotient its start and divide states. A pixel takes
// four weights at green sites and eight at red and blue sites.
// ============================================================================
module bayer_demosaic_edge_aware_top
    import dmsc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in              i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out                  o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [FW_W-1:0] r_fw;
    logic [FH_W-1:0] r_fh;
    t_pattern        r_pat;
    logic            r_edge;

    logic [WW-1:0]   w_eff;
    logic [FH_W-1:0] h_eff;
    logic            geom_wr;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_job f_job;
    t_job q_job;

    always_comb begin
        if (r_fw == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_fw) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_fw);
        end
        h_eff   = (r_fh == '0) ? FH_W'(1) : r_fh;
        geom_wr = i_cfg_we && ((t_cfg_idx'(i_cfg_idx) == CFG_WIDTH)
                            || (t_cfg_idx'(i_cfg_idx) == CFG_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw   <= FW_W'(1024);
            r_fh   <= FH_W'(1);
            r_pat  <= PAT_RGGB;
            r_edge <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:   r_fw   <= i_cfg_data[FW_W-1:0];
                CFG_HEIGHT:  r_fh   <= i_cfg_data[FH_W-1:0];
                CFG_PATTERN: r_pat  <= t_pattern'(i_cfg_data[1:0]);
                CFG_EDGE:    r_edge <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    dmsc_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (geom_wr),
        .i_width   (w_eff),
        .i_height  (h_eff),
        .i_pattern (r_pat),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (i_in_data),
        .o_push    (q_push),
        .o_job     (f_job),
        .i_full    (q_full)
    );

    dmsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    dmsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (r_edge),
        .i_empty (q_empty),
        .i_job   (q_job),
        .o_pop   (q_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job written into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job taken from an empty queue");

    a_pop_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_out_valid)
        else $error("finished job left no output transfer pending");

endmodule
`default_nettype wire
